// ===== hw/rtl/ptv_pkg.sv =====
// Shared types and constants for the pose to view matrix block.
// Used by every module in hw/rtl; depends on nothing.
package ptv_pkg;

  localparam int TOL_W  = 31;
  localparam int ADDR_W = 3;
  localparam int Q_W    = 16;
  localparam int EYE_W  = 32;
  localparam int VAL_W  = 32;
  localparam int RAW_W  = 34;
  localparam int ROT_W  = 20;
  localparam int PROD_W = ROT_W + EYE_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RAW_SH = 14;
  localparam int XL_SH  = 16;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(10737418);
  localparam logic signed [RAW_W-1:0] ONE_Q30 = RAW_W'(1073741824);

  // Register index as seen in the word-address bit of paddr.
  localparam logic REG_NORM_TOL = 1'b0;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_TRANS = 2'd3;

  typedef struct packed {
    logic signed [EYE_W-1:0] eye_x;
    logic signed [EYE_W-1:0] eye_y;
    logic signed [EYE_W-1:0] eye_z;
    logic signed [Q_W-1:0]   quat_x;
    logic signed [Q_W-1:0]   quat_y;
    logic signed [Q_W-1:0]   quat_z;
    logic signed [Q_W-1:0]   quat_w;
  } pose_t;

  typedef struct packed {
    logic [1:0]              row_index;
    logic signed [VAL_W-1:0] value_a;
    logic signed [VAL_W-1:0] value_b;
    logic signed [VAL_W-1:0] value_c;
    logic                    ok;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic                           ok;
    logic [2:0][2:0][ROT_W-1:0]     r;
    logic [2:0][EYE_W-1:0]          eye;
  } rot_t;

  typedef struct packed {
    logic                           ok;
    logic [2:0][2:0][ROT_W-1:0]     r;
    logic [2:0][VAL_W-1:0]          t;
  } xlat_t;

endpackage

// ===== hw/rtl/ptv_rot.sv =====
// Rotation front end: quaternion products, norm check and rounded rotation terms.
// Three register stages; depends on ptv_pkg.
module ptv_rot (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  ptv_pkg::pose_t              pose,
  input  logic [ptv_pkg::TOL_W-1:0]   tol,
  output logic                        out_valid,
  output ptv_pkg::rot_t               rot
);

  localparam int RW   = ptv_pkg::RAW_W;
  localparam int HALF = 2 ** (ptv_pkg::RAW_SH - 1);

  function automatic logic [ptv_pkg::ROT_W-1:0] round_q(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] t;
    t = v + RW'(HALF) - RW'(v[RW-1]);
    return t[ptv_pkg::ROT_W+ptv_pkg::RAW_SH-1:ptv_pkg::RAW_SH];
  endfunction

  logic                               v1_r, v2_r, v3_r;
  logic signed [31:0]                 xx_r, yy_r, zz_r, ww_r;
  logic signed [31:0]                 xy_r, xz_r, yz_r, xw_r, yw_r, zw_r;
  logic [2:0][ptv_pkg::EYE_W-1:0]     eye1_r, eye2_r;
  logic signed [RW-1:0]               raw_r [3][3];
  logic signed [RW-1:0]               raw_nxt [3][3];
  logic signed [RW-1:0]               dev_r, dev_nxt;
  logic [RW-1:0]                      absdev;
  ptv_pkg::rot_t                      rot_r, rot_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r   <= 32'(pose.quat_x) * 32'(pose.quat_x);
      yy_r   <= 32'(pose.quat_y) * 32'(pose.quat_y);
      zz_r   <= 32'(pose.quat_z) * 32'(pose.quat_z);
      ww_r   <= 32'(pose.quat_w) * 32'(pose.quat_w);
      xy_r   <= 32'(pose.quat_x) * 32'(pose.quat_y);
      xz_r   <= 32'(pose.quat_x) * 32'(pose.quat_z);
      yz_r   <= 32'(pose.quat_y) * 32'(pose.quat_z);
      xw_r   <= 32'(pose.quat_x) * 32'(pose.quat_w);
      yw_r   <= 32'(pose.quat_y) * 32'(pose.quat_w);
      zw_r   <= 32'(pose.quat_z) * 32'(pose.quat_w);
      eye1_r <= {pose.eye_z, pose.eye_y, pose.eye_x};
      eye2_r <= eye1_r;
      raw_r  <= raw_nxt;
      dev_r  <= dev_nxt;
      rot_r  <= rot_nxt;
    end
  end

  always_comb begin
    raw_nxt[0][0] = ptv_pkg::ONE_Q30 - ((RW'(yy_r) + RW'(zz_r)) <<< 1);
    raw_nxt[0][1] = (RW'(xy_r) - RW'(zw_r)) <<< 1;
    raw_nxt[0][2] = (RW'(xz_r) + RW'(yw_r)) <<< 1;
    raw_nxt[1][0] = (RW'(xy_r) + RW'(zw_r)) <<< 1;
    raw_nxt[1][1] = ptv_pkg::ONE_Q30 - ((RW'(xx_r) + RW'(zz_r)) <<< 1);
    raw_nxt[1][2] = (RW'(yz_r) - RW'(xw_r)) <<< 1;
    raw_nxt[2][0] = (RW'(xz_r) - RW'(yw_r)) <<< 1;
    raw_nxt[2][1] = (RW'(yz_r) + RW'(xw_r)) <<< 1;
    raw_nxt[2][2] = ptv_pkg::ONE_Q30 - ((RW'(xx_r) + RW'(yy_r)) <<< 1);
    dev_nxt = RW'(xx_r) + RW'(yy_r) + RW'(zz_r) + RW'(ww_r) - ptv_pkg::ONE_Q30;
  end

  always_comb begin
    absdev = dev_r[RW-1] ? (~dev_r + 1'b1) : dev_r;
    rot_nxt.ok  = (absdev <= RW'(tol));
    rot_nxt.eye = eye2_r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot_nxt.r[i][j] = round_q(raw_r[i][j]);
      end
    end
  end

  assign out_valid = v3_r;
  assign rot       = rot_r;

endmodule

// ===== hw/rtl/ptv_xlat.sv =====
// Translation back end: products of rotation terms and eye position, sums,
// negation, rounding and saturation. Three register stages; depends on ptv_pkg.
module ptv_xlat (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  ptv_pkg::rot_t  rot,
  output logic           out_valid,
  output ptv_pkg::xlat_t xlat
);

  localparam int PW   = ptv_pkg::PROD_W;
  localparam int SW   = ptv_pkg::SUM_W;
  localparam int HALF = 2 ** (ptv_pkg::XL_SH - 1);
  localparam int TOP  = ptv_pkg::XL_SH + ptv_pkg::VAL_W - 1;

  logic                                     v4_r, v5_r, v6_r;
  logic signed [PW-1:0]                     prod_r [3][3];
  logic signed [PW-1:0]                     prod_nxt [3][3];
  logic signed [SW-1:0]                     sum_r [3];
  logic signed [SW-1:0]                     sum_nxt [3];
  logic                                     ok4_r, ok5_r;
  logic [2:0][2:0][ptv_pkg::ROT_W-1:0]      r4_r, r5_r;
  ptv_pkg::xlat_t                           xlat_r, xlat_nxt;
  logic signed [SW-1:0]                     neg_v [3];
  logic                                     pos [3];
  logic [SW-TOP-1:0]                        hi [3];
  logic signed [PW-1:0]                     op_a, op_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v4_r <= in_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      ok4_r  <= rot.ok;
      r4_r   <= rot.r;
      sum_r  <= sum_nxt;
      ok5_r  <= ok4_r;
      r5_r   <= r4_r;
      xlat_r <= xlat_nxt;
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        op_a = PW'($signed(rot.r[i][j]));
        op_b = PW'($signed(rot.eye[i]));
        prod_nxt[i][j] = op_a * op_b;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum_nxt[j] = SW'(prod_r[0][j]) + SW'(prod_r[1][j]) + SW'(prod_r[2][j]);
    end
  end

  always_comb begin
    xlat_nxt.ok = ok5_r;
    xlat_nxt.r  = r5_r;
    for (int j = 0; j < 3; j++) begin
      pos[j]   = !sum_r[j][SW-1] && (|sum_r[j]);
      neg_v[j] = SW'(HALF) - SW'(pos[j]) - sum_r[j];
      hi[j]    = neg_v[j][SW-1:TOP];
      if ((&hi[j]) || !(|hi[j])) begin
        xlat_nxt.t[j] = neg_v[j][TOP:ptv_pkg::XL_SH];
      end else if (neg_v[j][SW-1]) begin
        xlat_nxt.t[j] = {1'b1, {(ptv_pkg::VAL_W-1){1'b0}}};
      end else begin
        xlat_nxt.t[j] = {1'b0, {(ptv_pkg::VAL_W-1){1'b1}}};
      end
    end
  end

  assign out_valid = v6_r;
  assign xlat      = xlat_r;

endmodule

// ===== hw/rtl/ptv_ser.sv =====
// Output serializer: holds one finished pose and sends its rows one beat per cycle.
// Depends on ptv_pkg.
module ptv_ser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tail_valid,
  input  ptv_pkg::xlat_t   tail,
  output logic             load,
  output logic             out_valid,
  output ptv_pkg::result_t out_result
);

  logic           act_r, act_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  ptv_pkg::xlat_t buf_r;
  logic           last_now;

  assign last_now = act_r && (!buf_r.ok || (cnt_r == ptv_pkg::ROW_TRANS));
  assign load     = tail_valid && (!act_r || last_now);

  always_comb begin
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    if (load) begin
      act_nxt = 1'b1;
      cnt_nxt = ptv_pkg::ROW_FIRST;
    end else if (last_now) begin
      act_nxt = 1'b0;
    end else if (act_r) begin
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= ptv_pkg::ROW_FIRST;
    end else begin
      act_r <= act_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= tail;
    end
  end

  always_comb begin
    out_result.row_index = cnt_r;
    out_result.ok        = buf_r.ok;
    out_result.last      = last_now;
    case (cnt_r)
      2'd0: begin
        out_result.value_a = ptv_pkg::VAL_W'($signed(buf_r.r[0][0]));
        out_result.value_b = ptv_pkg::VAL_W'($signed(buf_r.r[0][1]));
        out_result.value_c = ptv_pkg::VAL_W'($signed(buf_r.r[0][2]));
      end
      2'd1: begin
        out_result.value_a = ptv_pkg::VAL_W'($signed(buf_r.r[1][0]));
        out_result.value_b = ptv_pkg::VAL_W'($signed(buf_r.r[1][1]));
        out_result.value_c = ptv_pkg::VAL_W'($signed(buf_r.r[1][2]));
      end
      2'd2: begin
        out_result.value_a = ptv_pkg::VAL_W'($signed(buf_r.r[2][0]));
        out_result.value_b = ptv_pkg::VAL_W'($signed(buf_r.r[2][1]));
        out_result.value_c = ptv_pkg::VAL_W'($signed(buf_r.r[2][2]));
      end
      default: begin
        out_result.value_a = buf_r.t[0];
        out_result.value_b = buf_r.t[1];
        out_result.value_c = buf_r.t[2];
      end
    endcase
    if (!buf_r.ok) begin
      out_result.value_a = '0;
      out_result.value_b = '0;
      out_result.value_c = '0;
    end
  end

  assign out_valid = act_r;

endmodule

// ===== hw/rtl/pose_to_view_matrix_core.sv =====
// Pose to view matrix core: register block, six-stage datapath and row serializer.
// Depends on ptv_pkg, ptv_rot, ptv_xlat and ptv_ser.
//
// A pose beat is taken on in_pose at a rising edge where start is high and busy
// is low. The quaternion norm is checked against norm_tolerance; a rejected pose
// gives one beat with ok low, an accepted pose gives four beats on out_result
// (rotation rows 0 to 2, then the translation row), each marked by out_valid for
// one cycle, with last set on the final beat of the pose.
// The first beat appears once the pose has passed the six register stages and
// the serializer has loaded it; the rows follow on consecutive cycles. A new pose
// can enter every cycle while busy is low; the serializer drains one row per cycle,
// so an accepted pose holds it for four rows and rejected poses pass one per cycle.
// busy is high while the last pipeline stage holds a pose the serializer cannot
// take yet; the whole pipeline then holds its contents.
// The receiver cannot stall: every beat is taken in the cycle it is shown.
// norm_tolerance sits at APB byte address 0; the user must write it only while idle
// (not enforced by the block). Reset clears the pipeline and sets it to about 0.01.
module pose_to_view_matrix_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ptv_pkg::pose_t                in_pose,
  output logic                          out_valid,
  output ptv_pkg::result_t              out_result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptv_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [ptv_pkg::TOL_W-1:0] tol_r;
  logic                      en;
  logic                      accept;
  logic                      rot_valid;
  ptv_pkg::rot_t             rot;
  logic                      tail_valid;
  ptv_pkg::xlat_t            tail;
  logic                      load;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ptv_pkg::ADDR_W-1] == ptv_pkg::REG_NORM_TOL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= ptv_pkg::TOL_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      tol_r <= pwdata[ptv_pkg::TOL_W-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(tol_r) : 32'd0;

  assign en     = !tail_valid || load;
  assign busy   = !en;
  assign accept = start && en;

  ptv_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (accept),
    .pose      (in_pose),
    .tol       (tol_r),
    .out_valid (rot_valid),
    .rot       (rot)
  );

  ptv_xlat u_xlat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rot_valid),
    .rot       (rot),
    .out_valid (tail_valid),
    .xlat      (tail)
  );

  ptv_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail_valid (tail_valid),
    .tail       (tail),
    .load       (load),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

`ifndef SYNTHESIS
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result.last |=>
      out_valid && (out_result.row_index == $past(out_result.row_index) + 2'd1))
    else $error("row sequence broken inside a pose");

  a_new_pose_row0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.last |=>
      !out_valid || (out_result.row_index == ptv_pkg::ROW_FIRST))
    else $error("pose does not start at row 0");

  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result.ok |->
      out_result.last && (out_result.row_index == ptv_pkg::ROW_FIRST))
    else $error("rejected pose is not a single beat");

  a_busy_tail: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> tail_valid && out_valid)
    else $error("busy without a pending pose");
`endif

endmodule
